// ===== design/swm_pkg.sv =====
// Shared types and constants for the sliding-window median filter.
// Used by swm_cell, swm_chain and sliding_window_median; depends on nothing.
`default_nettype none

package swm_pkg;

    // Window geometry
    localparam int WINDOW_MAX = 64;
    localparam int IDX_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

    // Field widths
    localparam int DATA_W = 32;
    localparam int OP_W   = 2;
    localparam int STS_W  = 2;
    localparam int WL_W   = 7;

    // Register port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic                 REG_WINDOW_LENGTH = 1'b0;
    localparam logic [WL_W-1:0]      WL_RESET          = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_UPDATE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [STS_W-1:0] {
        STS_OK          = 2'd0,
        STS_LOAD_FULL   = 2'd1,
        STS_UPDATE_PART = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_INSERT,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_INSERT,
        CM_REMOVE
    } t_cell_mode;

    // Control broadcast to every cell of the sorted chain
    typedef struct packed {
        t_cell_mode               mode;
        logic signed [DATA_W-1:0] key;    // value to insert, or value to remove
        logic [CNT_W-1:0]         count;  // occupied entries before an insert
        logic [CNT_W-1:0]         len;    // effective window length
        logic [CNT_W-1:0]         last;   // len - 1
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== design/swm_cell.sv =====
// One entry of the sorted chain: holds a sample and shifts it to a neighbour.
// Depends on swm_pkg.
`default_nettype none

module swm_cell (
    input  wire logic                              i_clk,
    input  wire swm_pkg::t_cell_ctrl               i_ctrl,
    input  wire logic                              i_found,
    input  wire logic [swm_pkg::IDX_W-1:0]         i_index,
    input  wire logic signed [swm_pkg::DATA_W-1:0] i_left_value,
    input  wire logic                              i_left_shift,
    input  wire logic signed [swm_pkg::DATA_W-1:0] i_right_value,
    output logic signed [swm_pkg::DATA_W-1:0]      o_value,
    output logic                                   o_shift,
    output logic                                   o_eq
);

    logic signed [swm_pkg::DATA_W-1:0] r_value;
    logic signed [swm_pkg::DATA_W-1:0] n_value;
    logic signed [swm_pkg::DATA_W-1:0] w_key;
    logic [swm_pkg::CNT_W-1:0]         w_idx;
    logic                              w_gt;
    logic                              w_ge;
    logic                              w_below;
    logic                              w_place;
    logic                              w_remove;

    assign w_key   = i_ctrl.key;
    assign w_idx   = swm_pkg::CNT_W'(i_index);
    assign w_gt    = r_value > w_key;
    assign w_ge    = r_value >= w_key;
    assign w_below = w_idx < i_ctrl.count;

    // Insert: entries above the key move up one place, the key drops into the gap
    assign o_shift = (i_ctrl.mode == swm_pkg::CM_INSERT) && w_below && w_gt;
    assign w_place = (w_idx == i_ctrl.count) || (w_below && w_gt);

    // Remove: from the first entry >= key (the first equal one) pull down
    assign w_remove = i_found && w_ge && (w_idx < i_ctrl.last);
    assign o_eq     = (r_value == w_key) && (w_idx < i_ctrl.len);

    always_comb begin
        n_value = r_value;
        case (i_ctrl.mode)
            swm_pkg::CM_INSERT: begin
                if (i_left_shift) begin
                    n_value = i_left_value;
                end else if (w_place) begin
                    n_value = w_key;
                end
            end
            swm_pkg::CM_REMOVE: begin
                if (w_remove) begin
                    n_value = i_right_value;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

// ===== design/swm_chain.sv =====
// Row of swm_cell entries forming the sorted copy of the window.
// Depends on swm_pkg and swm_cell.
`default_nettype none

module swm_chain (
    input  wire logic                              i_clk,
    input  wire swm_pkg::t_cell_ctrl               i_ctrl,
    input  wire logic [swm_pkg::IDX_W-1:0]         i_med_index,
    output logic signed [swm_pkg::DATA_W-1:0]      o_median
);

    logic signed [swm_pkg::DATA_W-1:0] w_value [swm_pkg::WINDOW_MAX];
    logic signed [swm_pkg::DATA_W-1:0] w_left  [swm_pkg::WINDOW_MAX];
    logic signed [swm_pkg::DATA_W-1:0] w_right [swm_pkg::WINDOW_MAX];
    logic [swm_pkg::WINDOW_MAX-1:0]    w_shift;
    logic [swm_pkg::WINDOW_MAX-1:0]    w_lshift;
    logic [swm_pkg::WINDOW_MAX-1:0]    w_eq;
    logic                              w_found;

    // Any entry of the window equal to the value being removed
    assign w_found = |w_eq;

    for (genvar g = 0; g < swm_pkg::WINDOW_MAX; g++) begin : g_cell
        // Neighbour wiring, ends tied off
        if (g == 0) begin : g_first
            assign w_left[g]   = '0;
            assign w_lshift[g] = 1'b0;
        end else begin : g_mid_l
            assign w_left[g]   = w_value[g-1];
            assign w_lshift[g] = w_shift[g-1];
        end
        if (g == swm_pkg::WINDOW_MAX - 1) begin : g_last
            assign w_right[g] = w_value[g];
        end else begin : g_mid_r
            assign w_right[g] = w_value[g+1];
        end

        swm_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (i_ctrl),
            .i_found       (w_found),
            .i_index       (swm_pkg::IDX_W'(g)),
            .i_left_value  (w_left[g]),
            .i_left_shift  (w_lshift[g]),
            .i_right_value (w_right[g]),
            .o_value       (w_value[g]),
            .o_shift       (w_shift[g]),
            .o_eq          (w_eq[g])
        );
    end

    assign o_median = w_value[i_med_index];

endmodule

`default_nettype wire

// ===== design/sliding_window_median.sv =====
// Sliding-window median filter top level: register port, control, window RAM.
// Depends on swm_pkg and swm_chain.
//
//   channel   signals                           direction
//   input     i_valid/o_ready, i_op, i_sample   item in
//   output    o_valid/i_ready, o_median,        item out
//             o_ready_res, o_status
//   config    psel/penable/pwrite/paddr/pwdata  register access
//             prdata/pready
//
// With the output register free, loads, clears, unused ops and refused updates
// go through the accepting cycle (registered read of the arrival RAM), one pass
// through the sorted cell chain, then the result register load. An accepted
// update makes a remove pass and an insert pass through the chain instead.
// Reset is synchronous, active low; the stores need no clearing pass.
// A finished result waits in the output register while the next item is
// taken; the item after that waits until the output register frees.
`default_nettype none

module sliding_window_median (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // item in
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [swm_pkg::OP_W-1:0]            i_op,
    input  wire logic signed [swm_pkg::DATA_W-1:0]   i_sample,
    // item out
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [swm_pkg::DATA_W-1:0]        o_median,
    output logic                                     o_ready_res,
    output logic [swm_pkg::STS_W-1:0]                o_status,
    // register port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [swm_pkg::APB_AW-1:0]          paddr,
    input  wire logic [swm_pkg::APB_DW-1:0]          pwdata,
    output logic [swm_pkg::APB_DW-1:0]               prdata,
    output logic                                     pready
);

    swm_pkg::t_state                   r_state, n_state;
    logic [swm_pkg::OP_W-1:0]          r_op;
    logic signed [swm_pkg::DATA_W-1:0] r_sample;
    logic [swm_pkg::CNT_W-1:0]         r_fill, n_fill;
    logic [swm_pkg::IDX_W-1:0]         r_pos, n_pos;
    logic [swm_pkg::WL_W-1:0]          r_wl;
    logic [swm_pkg::STS_W-1:0]         r_status, n_status;
    logic signed [swm_pkg::DATA_W-1:0] r_rd_data;
    logic signed [swm_pkg::DATA_W-1:0] r_mem [swm_pkg::WINDOW_MAX];

    logic                              r_o_valid;
    logic signed [swm_pkg::DATA_W-1:0] r_o_median;
    logic                              r_o_ready_res;
    logic [swm_pkg::STS_W-1:0]         r_o_status;
    logic                              n_o_load;

    logic [swm_pkg::CNT_W-1:0]         w_len;
    logic [swm_pkg::CNT_W-1:0]         w_last;
    logic [swm_pkg::IDX_W-1:0]         w_pos_eff;
    logic [swm_pkg::CNT_W-1:0]         w_pos_inc;
    logic                              w_full;
    logic                              w_accept;
    logic                              w_wr;
    logic                              w_mem_we;
    logic [swm_pkg::IDX_W-1:0]         w_mem_addr;
    logic signed [swm_pkg::DATA_W-1:0] w_median;
    swm_pkg::t_cell_ctrl               w_ctrl;

    // Effective window length, clamped to 1..WINDOW_MAX
    always_comb begin
        if (r_wl == '0) begin
            w_len = swm_pkg::CNT_W'(1);
        end else if (int'(r_wl) > swm_pkg::WINDOW_MAX) begin
            w_len = swm_pkg::CNT_W'(swm_pkg::WINDOW_MAX);
        end else begin
            w_len = swm_pkg::CNT_W'(r_wl);
        end
    end

    assign w_last    = w_len - swm_pkg::CNT_W'(1);
    assign w_pos_eff = (swm_pkg::CNT_W'(r_pos) < w_len) ? r_pos : '0;
    assign w_pos_inc = swm_pkg::CNT_W'(w_pos_eff) + swm_pkg::CNT_W'(1);
    assign w_full    = r_fill >= w_len;
    assign w_accept  = i_valid && o_ready;
    assign o_ready   = (r_state == swm_pkg::ST_IDLE);

    // Register port
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign prdata = (paddr[swm_pkg::APB_AW-1] == swm_pkg::REG_WINDOW_LENGTH)
                  ? swm_pkg::APB_DW'(r_wl) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl <= swm_pkg::WL_RESET;
        end else if (w_wr && paddr[swm_pkg::APB_AW-1] == swm_pkg::REG_WINDOW_LENGTH) begin
            r_wl <= pwdata[swm_pkg::WL_W-1:0];
        end
    end

    // Sorted chain
    swm_chain u_chain (
        .i_clk       (i_clk),
        .i_ctrl      (w_ctrl),
        .i_med_index (swm_pkg::IDX_W'(w_len >> 1)),
        .o_median    (w_median)
    );

    // Next state, chain control and RAM write
    always_comb begin
        n_state       = r_state;
        n_fill        = r_fill;
        n_pos         = r_pos;
        n_status      = r_status;
        n_o_load      = 1'b0;
        w_mem_we      = 1'b0;
        w_mem_addr    = w_pos_eff;
        w_ctrl.mode   = swm_pkg::CM_HOLD;
        w_ctrl.key    = r_sample;
        w_ctrl.count  = r_fill;
        w_ctrl.len    = w_len;
        w_ctrl.last   = w_last;
        case (r_state)
            swm_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = swm_pkg::ST_EXEC;
                end
            end
            swm_pkg::ST_EXEC: begin
                n_status = swm_pkg::STS_OK;
                n_state  = swm_pkg::ST_DONE;
                case (r_op)
                    swm_pkg::OP_LOAD: begin
                        if (w_full) begin
                            n_status = swm_pkg::STS_LOAD_FULL;
                        end else begin
                            w_ctrl.mode = swm_pkg::CM_INSERT;
                            w_mem_we    = 1'b1;
                            w_mem_addr  = r_fill[swm_pkg::IDX_W-1:0];
                            n_fill      = r_fill + swm_pkg::CNT_W'(1);
                        end
                    end
                    swm_pkg::OP_UPDATE: begin
                        if (!w_full) begin
                            n_status = swm_pkg::STS_UPDATE_PART;
                        end else begin
                            w_ctrl.mode = swm_pkg::CM_REMOVE;
                            w_ctrl.key  = r_rd_data;
                            w_mem_we    = 1'b1;
                            n_pos       = (w_pos_inc >= w_len) ? '0
                                        : w_pos_inc[swm_pkg::IDX_W-1:0];
                            n_state     = swm_pkg::ST_INSERT;
                        end
                    end
                    swm_pkg::OP_CLEAR: begin
                        n_fill = '0;
                        n_pos  = '0;
                    end
                    default: begin
                        n_status = swm_pkg::STS_OK;
                    end
                endcase
            end
            swm_pkg::ST_INSERT: begin
                w_ctrl.mode  = swm_pkg::CM_INSERT;
                w_ctrl.count = w_last;
                n_state      = swm_pkg::ST_DONE;
            end
            swm_pkg::ST_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_load = 1'b1;
                    n_state  = swm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = swm_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= swm_pkg::ST_IDLE;
            r_fill   <= '0;
            r_pos    <= '0;
            r_status <= swm_pkg::STS_OK;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_pos    <= n_pos;
            r_status <= n_status;
        end
    end

    // Accepted item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_op;
            r_sample <= i_sample;
        end
    end

    // Arrival RAM: one write port, registered read of the oldest entry
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= r_sample;
        end
        r_rd_data <= r_mem[w_pos_eff];
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (n_o_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_o_load) begin
            r_o_median    <= w_full ? w_median : '0;
            r_o_ready_res <= w_full;
            r_o_status    <= r_status;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_median    = r_o_median;
    assign o_ready_res = r_o_ready_res;
    assign o_status    = r_o_status;

endmodule

`default_nettype wire
